// ===== design/rlc_pkg.sv =====
// rlc_pkg: shared types and codes for the reference-counted lru entry cache
// no dependencies; imported by refcounted_lru_entry_cache and its testbench
package rlc_pkg;

    // action codes carried by the action field
    localparam logic [2:0] ACT_GET     = 3'd0;
    localparam logic [2:0] ACT_PUT     = 3'd1;
    localparam logic [2:0] ACT_CREATE  = 3'd2;
    localparam logic [2:0] ACT_DESTROY = 3'd3;
    localparam logic [2:0] ACT_DIRTY   = 3'd4;
    localparam logic [2:0] ACT_SYNC    = 3'd5;
    localparam logic [2:0] ACT_SYNCALL = 3'd6;

    // status codes of a result word
    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_FULL  = 2'd1;
    localparam logic [1:0] ST_NOFS  = 2'd2;

    // reference count ceiling
    localparam logic [15:0] REF_MAX = 16'hFFFF;

    // sequencer states
    typedef enum logic [4:0] {
        S_CLR,
        S_IDLE,
        S_SCAN,
        S_HIT_WAIT,
        S_TK_WAIT,
        S_TK_CK,
        S_UNLINK,
        S_FIN,
        S_PUT_WAIT,
        S_PUT_CK,
        S_DES,
        S_APP1,
        S_APP2,
        S_SY_WAIT,
        S_SY_CK,
        S_SALL,
        S_DONE
    } state_t;

endpackage

// ===== design/refcounted_lru_entry_cache.sv =====
// refcounted_lru_entry_cache: keyed entry table with reference counts and a free order
// depends on rlc_pkg; holds key, count and link memories and one sequencer
//
//  channel   handshake             payload
//  command   start, busy           action, fs_id, inode_number, entry_index
//  result    done (one cycle)      status, slot, hit, evict_writeback, new_inode,
//                                  was_dirty, synced_count
//
// After reset a clearing pass over all ENTRIES entries initialises the memories; busy stays high.
// Get scans the table one entry a cycle; on a miss, like Create, it walks the free order for
// the oldest entry with no references. Sync all sweeps the whole table. The memories share a
// single read address; done pulses once.
module refcounted_lru_entry_cache #(
    parameter int ENTRIES = 256
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [2:0]  action,
    input  logic [15:0] fs_id,
    input  logic [31:0] inode_number,
    input  logic [7:0]  entry_index,
    output logic        done,
    output logic [1:0]  status,
    output logic [7:0]  slot,
    output logic        hit,
    output logic        evict_writeback,
    output logic [31:0] new_inode,
    output logic        was_dirty,
    output logic [8:0]  synced_count
);
    import rlc_pkg::*;

    localparam int IW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int PW = $clog2(ENTRIES + 1);
    localparam logic [PW-1:0] NIL = PW'(ENTRIES);
    localparam logic [PW-1:0] LAST = PW'(ENTRIES - 1);

    state_t state_reg, state_next;

    logic [2:0]  op_reg, op_next;
    logic [15:0] fs_reg, fs_next;
    logic [31:0] ino_reg, ino_next;
    logic [PW-1:0] e_reg, e_next;
    logic [PW-1:0] cnt_reg, cnt_next;
    logic chk_v_reg, chk_v_next;
    logic [IW-1:0] chk_idx_reg, chk_idx_next;
    logic [PW-1:0] head_reg, head_next, tail_reg, tail_next;
    logic [31:0] nino_reg, nino_next;
    logic [ENTRIES-1:0] valid_reg, valid_next, dirty_reg, dirty_next, infree_reg, infree_next;

    logic [1:0]  status_reg, status_next;
    logic [7:0]  slot_reg, slot_next;
    logic        hit_reg, hit_next, wb_reg, wb_next, wasd_reg, wasd_next;
    logic [31:0] newino_reg, newino_next;
    logic [8:0]  scnt_reg, scnt_next;

    // memories: keys, counts and free-order links
    logic [47:0]   key_mem [ENTRIES];
    logic [15:0]   ref_mem [ENTRIES];
    logic [PW-1:0] nxt_mem [ENTRIES];
    logic [PW-1:0] prv_mem [ENTRIES];

    logic [IW-1:0] rd_addr;
    logic [47:0]   key_rd;
    logic [15:0]   ref_rd;
    logic [PW-1:0] nxt_rd, prv_rd;

    logic          key_we, ref_we, nxt_we, prv_we;
    logic [IW-1:0] key_wa, ref_wa, nxt_wa, prv_wa;
    logic [47:0]   key_wd;
    logic [15:0]   ref_wd;
    logic [PW-1:0] nxt_wd, prv_wd;

    // shared conditions
    logic          accept, idx_ok, scan_match, scan_end, put_zero;
    logic [IW-1:0] e_ix;
    logic [15:0]   ref_dec;

    assign accept     = start && !busy;
    assign idx_ok     = 13'(entry_index) < 13'(ENTRIES);
    assign e_ix       = e_reg[IW-1:0];
    assign scan_match = chk_v_reg && valid_reg[chk_idx_reg]
                        && key_rd[15:0] == fs_reg && key_rd[47:16] == ino_reg;
    assign scan_end   = (cnt_reg == NIL) && !chk_v_reg;
    assign ref_dec    = (ref_rd != 16'd0) ? ref_rd - 16'd1 : ref_rd;
    assign put_zero   = (ref_dec == 16'd0) && !infree_reg[e_ix];

    assign rd_addr = (state_reg == S_SCAN || state_reg == S_SALL) ? cnt_reg[IW-1:0] : e_ix;

    // memory read and write ports
    always_ff @(posedge clk)
    begin
        if (key_we)
        begin
            key_mem[key_wa] <= key_wd;
        end
        if (ref_we)
        begin
            ref_mem[ref_wa] <= ref_wd;
        end
        if (nxt_we)
        begin
            nxt_mem[nxt_wa] <= nxt_wd;
        end
        if (prv_we)
        begin
            prv_mem[prv_wa] <= prv_wd;
        end
        key_rd <= key_mem[rd_addr];
        ref_rd <= ref_mem[rd_addr];
        nxt_rd <= nxt_mem[rd_addr];
        prv_rd <= prv_mem[rd_addr];
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_CLR:
            begin
                if (cnt_reg == LAST)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (accept)
                begin
                    unique case (action)
                        ACT_GET:
                        begin
                            state_next = (fs_id == 16'd0) ? S_DONE : S_SCAN;
                        end
                        ACT_CREATE:
                        begin
                            state_next = (head_reg == NIL) ? S_DONE : S_TK_WAIT;
                        end
                        ACT_PUT:     state_next = idx_ok ? S_PUT_WAIT : S_DONE;
                        ACT_DESTROY: state_next = idx_ok ? S_DES : S_DONE;
                        ACT_SYNC:    state_next = idx_ok ? S_SY_WAIT : S_DONE;
                        ACT_SYNCALL: state_next = S_SALL;
                        default:     state_next = S_DONE;
                    endcase
                end
            end
            S_SCAN:
            begin
                if (scan_match)
                begin
                    state_next = S_HIT_WAIT;
                end
                else if (scan_end)
                begin
                    state_next = (head_reg == NIL) ? S_DONE : S_TK_WAIT;
                end
            end
            S_HIT_WAIT: state_next = infree_reg[e_ix] ? S_UNLINK : S_FIN;
            S_TK_WAIT:  state_next = S_TK_CK;
            S_TK_CK:
            begin
                if (ref_rd == 16'd0)
                begin
                    state_next = infree_reg[e_ix] ? S_UNLINK : S_FIN;
                end
                else if (nxt_rd == NIL || cnt_reg + PW'(1) == NIL)
                begin
                    state_next = S_DONE;
                end
                else
                begin
                    state_next = S_TK_WAIT;
                end
            end
            S_UNLINK:   state_next = S_FIN;
            S_FIN:      state_next = S_DONE;
            S_PUT_WAIT: state_next = S_PUT_CK;
            S_PUT_CK:   state_next = put_zero ? S_APP1 : S_DONE;
            S_DES:      state_next = infree_reg[e_ix] ? S_DONE : S_APP1;
            S_APP1:     state_next = (tail_reg != NIL) ? S_APP2 : S_DONE;
            S_APP2:     state_next = S_DONE;
            S_SY_WAIT:  state_next = S_SY_CK;
            S_SY_CK:    state_next = S_DONE;
            S_SALL:     state_next = scan_end ? S_DONE : S_SALL;
            S_DONE:     state_next = S_IDLE;
            default:    state_next = S_IDLE;
        endcase
    end

    // datapath and memory control
    always_comb
    begin
        op_next      = op_reg;
        fs_next      = fs_reg;
        ino_next     = ino_reg;
        e_next       = e_reg;
        cnt_next     = cnt_reg;
        chk_v_next   = 1'b0;
        chk_idx_next = cnt_reg[IW-1:0];
        head_next    = head_reg;
        tail_next    = tail_reg;
        nino_next    = nino_reg;
        valid_next   = valid_reg;
        dirty_next   = dirty_reg;
        infree_next  = infree_reg;
        status_next  = status_reg;
        slot_next    = slot_reg;
        hit_next     = hit_reg;
        wb_next      = wb_reg;
        wasd_next    = wasd_reg;
        newino_next  = newino_reg;
        scnt_next    = scnt_reg;
        key_we = 1'b0; key_wa = e_ix; key_wd = {ino_reg, fs_reg};
        ref_we = 1'b0; ref_wa = e_ix; ref_wd = 16'd1;
        nxt_we = 1'b0; nxt_wa = e_ix; nxt_wd = NIL;
        prv_we = 1'b0; prv_wa = e_ix; prv_wd = tail_reg;
        unique case (state_reg)
            // clearing pass: zero keys and counts, chain links in index order
            S_CLR:
            begin
                key_we = 1'b1; key_wa = cnt_reg[IW-1:0]; key_wd = 48'd0;
                ref_we = 1'b1; ref_wa = cnt_reg[IW-1:0]; ref_wd = 16'd0;
                nxt_we = 1'b1; nxt_wa = cnt_reg[IW-1:0]; nxt_wd = cnt_reg + PW'(1);
                prv_we = 1'b1; prv_wa = cnt_reg[IW-1:0];
                prv_wd = (cnt_reg == '0) ? NIL : cnt_reg - PW'(1);
                cnt_next = (cnt_reg == LAST) ? '0 : cnt_reg + PW'(1);
            end
            // take a command word and clear the result word
            S_IDLE:
            begin
                if (accept)
                begin
                    op_next     = action;
                    fs_next     = fs_id;
                    ino_next    = inode_number;
                    e_next      = PW'(entry_index);
                    cnt_next    = '0;
                    status_next = ST_OK;
                    slot_next   = 8'd0;
                    hit_next    = 1'b0;
                    wb_next     = 1'b0;
                    wasd_next   = 1'b0;
                    newino_next = 32'd0;
                    scnt_next   = 9'd0;
                    if (action == ACT_GET && fs_id == 16'd0)
                    begin
                        status_next = ST_NOFS;
                    end
                    if (action == ACT_CREATE)
                    begin
                        e_next = head_reg;
                        if (head_reg == NIL)
                        begin
                            status_next = ST_FULL;
                        end
                    end
                    if (action == ACT_DIRTY && idx_ok)
                    begin
                        dirty_next[IW'(entry_index)] = 1'b1;
                    end
                end
            end
            // key search, lowest matching entry wins
            S_SCAN:
            begin
                if (cnt_reg != NIL)
                begin
                    cnt_next   = cnt_reg + PW'(1);
                    chk_v_next = 1'b1;
                end
                if (scan_match)
                begin
                    e_next   = PW'(chk_idx_reg);
                    hit_next = 1'b1;
                end
                else if (scan_end)
                begin
                    e_next = head_reg;
                    cnt_next = '0;
                    if (head_reg == NIL)
                    begin
                        status_next = ST_FULL;
                    end
                end
            end
            // free-order walk for an entry with no references
            S_TK_CK:
            begin
                if (ref_rd == 16'd0)
                begin
                    wb_next = valid_reg[e_ix] & dirty_reg[e_ix];
                    valid_next[e_ix] = 1'b0;
                    dirty_next[e_ix] = 1'b0;
                end
                else
                begin
                    cnt_next = cnt_reg + PW'(1);
                    e_next   = nxt_rd;
                    if (nxt_rd == NIL || cnt_reg + PW'(1) == NIL)
                    begin
                        status_next = ST_FULL;
                    end
                end
            end
            // unlink from the free order
            S_UNLINK:
            begin
                infree_next[e_ix] = 1'b0;
                if (prv_rd != NIL)
                begin
                    nxt_we = 1'b1; nxt_wa = prv_rd[IW-1:0]; nxt_wd = nxt_rd;
                end
                else
                begin
                    head_next = nxt_rd;
                end
                if (nxt_rd != NIL)
                begin
                    prv_we = 1'b1; prv_wa = nxt_rd[IW-1:0]; prv_wd = prv_rd;
                end
                else
                begin
                    tail_next = prv_rd;
                end
            end
            // grant the entry
            S_FIN:
            begin
                slot_next = 8'(e_reg);
                ref_we = 1'b1;
                if (hit_reg)
                begin
                    ref_wd = (ref_rd == REF_MAX) ? ref_rd : ref_rd + 16'd1;
                end
                else
                begin
                    key_we = 1'b1;
                    valid_next[e_ix] = 1'b1;
                    dirty_next[e_ix] = (op_reg == ACT_CREATE);
                    if (op_reg == ACT_CREATE)
                    begin
                        key_wd      = {nino_reg, fs_reg};
                        newino_next = nino_reg;
                        nino_next   = nino_reg + 32'd1;
                    end
                end
            end
            // drop a reference
            S_PUT_CK:
            begin
                ref_we = 1'b1; ref_wd = ref_dec;
            end
            S_DES:
            begin
                ref_we = 1'b1; ref_wd = 16'd0;
                valid_next[e_ix] = 1'b0;
                dirty_next[e_ix] = 1'b0;
            end
            // append at the tail of the free order
            S_APP1:
            begin
                prv_we = 1'b1; prv_wd = tail_reg;
                nxt_we = 1'b1; nxt_wd = NIL;
                infree_next[e_ix] = 1'b1;
                if (tail_reg == NIL)
                begin
                    head_next = e_reg;
                    tail_next = e_reg;
                end
            end
            S_APP2:
            begin
                nxt_we = 1'b1; nxt_wa = tail_reg[IW-1:0]; nxt_wd = e_reg;
                tail_next = e_reg;
            end
            S_SY_CK:
            begin
                if (key_rd[15:0] == 16'd0)
                begin
                    status_next = ST_NOFS;
                end
                else
                begin
                    wasd_next = dirty_reg[e_ix];
                    dirty_next[e_ix] = 1'b0;
                end
            end
            // sync-all sweep
            S_SALL:
            begin
                if (cnt_reg != NIL)
                begin
                    cnt_next   = cnt_reg + PW'(1);
                    chk_v_next = 1'b1;
                end
                if (chk_v_reg && valid_reg[chk_idx_reg] && dirty_reg[chk_idx_reg])
                begin
                    scnt_next = scnt_reg + 9'd1;
                    if (key_rd[15:0] != 16'd0)
                    begin
                        dirty_next[chk_idx_reg] = 1'b0;
                    end
                end
            end
            default:
            begin
            end
        endcase
    end

    // registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_CLR;
            cnt_reg    <= '0;
            chk_v_reg  <= 1'b0;
            head_reg   <= '0;
            tail_reg   <= LAST;
            nino_reg   <= 32'd1;
            valid_reg  <= '0;
            dirty_reg  <= '0;
            infree_reg <= '1;
        end
        else
        begin
            state_reg  <= state_next;
            cnt_reg    <= cnt_next;
            chk_v_reg  <= chk_v_next;
            head_reg   <= head_next;
            tail_reg   <= tail_next;
            nino_reg   <= nino_next;
            valid_reg  <= valid_next;
            dirty_reg  <= dirty_next;
            infree_reg <= infree_next;
        end
    end

    // payload and result word
    always_ff @(posedge clk)
    begin
        op_reg      <= op_next;
        fs_reg      <= fs_next;
        ino_reg     <= ino_next;
        e_reg       <= e_next;
        chk_idx_reg <= chk_idx_next;
        status_reg  <= status_next;
        slot_reg    <= slot_next;
        hit_reg     <= hit_next;
        wb_reg      <= wb_next;
        wasd_reg    <= wasd_next;
        newino_reg  <= newino_next;
        scnt_reg    <= scnt_next;
    end

    assign busy            = (state_reg != S_IDLE);
    assign done            = (state_reg == S_DONE);
    assign status          = status_reg;
    assign slot            = slot_reg;
    assign hit             = hit_reg;
    assign evict_writeback = wb_reg;
    assign new_inode       = newino_reg;
    assign was_dirty       = wasd_reg;
    assign synced_count    = scnt_reg;

`ifndef SYNTHESIS
    a_done_pulse: assert property (@(posedge clk) disable iff (!rst_n) done |=> !done)
        else $error("done held for more than one cycle");
    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("command word accepted without going busy");
    a_ends_agree: assert property (@(posedge clk) disable iff (!rst_n)
        (head_reg == NIL) == (tail_reg == NIL))
        else $error("free order head and tail disagree on emptiness");
    a_full_slot: assert property (@(posedge clk) disable iff (!rst_n)
        (done && status == ST_FULL) |-> (slot == 8'd0 && !hit))
        else $error("full answer grants a slot");
    a_hit_clean: assert property (@(posedge clk) disable iff (!rst_n)
        (done && hit) |-> (status == ST_OK && !evict_writeback))
        else $error("hit answer carries an eviction");
`endif

endmodule

// ===== test/refcounted_lru_entry_cache_test.sv =====
// testbench for refcounted_lru_entry_cache: drives random and directed commands
// depends on rlc_pkg and the cache rtl; a scoreboard class predicts each result word
module refcounted_lru_entry_cache_test;
    import rlc_pkg::*;

    localparam int N = 256;
    localparam int NIL = N;
    localparam longint LIMIT = 3000000;

    typedef struct packed {
        logic [1:0]  status;
        logic [7:0]  slot;
        logic        hit;
        logic        evict_writeback;
        logic [31:0] new_inode;
        logic        was_dirty;
        logic [8:0]  synced_count;
    } word_t;

    // cache model and queue of predicted result words
    class cache_scoreboard;
        logic [31:0] key_ino [N];
        logic [15:0] key_fsid [N];
        logic [15:0] refs [N];
        bit valid [N];
        bit dirty [N];
        int nxt [N];
        int prv [N];
        bit in_free [N];
        int head, tail;
        logic [31:0] inode_ctr;
        word_t pending[$];
        int fails;

        function new();
            for (int i = 0; i < N; i++)
            begin
                key_ino[i] = 0; key_fsid[i] = 0; refs[i] = 0;
                valid[i] = 0; dirty[i] = 0;
                nxt[i] = i + 1; prv[i] = (i == 0) ? NIL : i - 1; in_free[i] = 1;
            end
            head = 0; tail = N - 1; inode_ctr = 1; fails = 0;
        endfunction

        function void unlink(int e);
            if (!in_free[e]) return;
            if (prv[e] < N) nxt[prv[e]] = nxt[e]; else head = nxt[e];
            if (nxt[e] < N) prv[nxt[e]] = prv[e]; else tail = prv[e];
            nxt[e] = NIL; prv[e] = NIL; in_free[e] = 0;
        endfunction

        function void append(int e);
            if (in_free[e]) return;
            prv[e] = tail; nxt[e] = NIL;
            if (tail < N) nxt[tail] = e; else head = e;
            tail = e; in_free[e] = 1;
        endfunction

        // oldest free entry with no references, evicting its mapping
        function int grab(output bit wb);
            int e;
            e = head; wb = 0;
            for (int s = 0; s < N && e < N; s++)
            begin
                if (refs[e] == 0)
                begin
                    if (valid[e])
                    begin
                        wb = dirty[e]; dirty[e] = 0; valid[e] = 0;
                    end
                    unlink(e);
                    return e;
                end
                e = nxt[e];
            end
            return NIL;
        endfunction

        // note an accepted command word and predict its result
        function void note_command(logic [2:0] act, logic [15:0] fs, logic [31:0] ino,
                                   logic [7:0] idx);
            word_t r;
            int e;
            bit wb;
            int cnt;
            r = '0;
            case (act)
                ACT_GET:
                begin
                    if (fs == 0) r.status = ST_NOFS;
                    else
                    begin
                        e = NIL;
                        for (int i = 0; i < N; i++)
                            if (e == NIL && valid[i] && key_fsid[i] == fs && key_ino[i] == ino)
                                e = i;
                        if (e != NIL)
                        begin
                            if (refs[e] != REF_MAX) refs[e]++;
                            unlink(e);
                            r.slot = 8'(e); r.hit = 1;
                        end
                        else
                        begin
                            e = grab(wb);
                            if (e == NIL) r.status = ST_FULL;
                            else
                            begin
                                key_ino[e] = ino; key_fsid[e] = fs; refs[e] = 1;
                                dirty[e] = 0; valid[e] = 1;
                                r.slot = 8'(e); r.evict_writeback = wb;
                            end
                        end
                    end
                end
                ACT_PUT:
                begin
                    if (refs[idx] > 0) refs[idx]--;
                    if (refs[idx] == 0) append(idx);
                end
                ACT_CREATE:
                begin
                    e = grab(wb);
                    if (e == NIL) r.status = ST_FULL;
                    else
                    begin
                        key_ino[e] = inode_ctr; key_fsid[e] = fs; refs[e] = 1;
                        dirty[e] = 1; valid[e] = 1;
                        r.slot = 8'(e); r.evict_writeback = wb; r.new_inode = inode_ctr;
                        inode_ctr++;
                    end
                end
                ACT_DESTROY:
                begin
                    valid[idx] = 0; dirty[idx] = 0; refs[idx] = 0;
                    append(idx);
                end
                ACT_DIRTY: dirty[idx] = 1;
                ACT_SYNC:
                begin
                    if (key_fsid[idx] == 0) r.status = ST_NOFS;
                    else
                    begin
                        r.was_dirty = dirty[idx]; dirty[idx] = 0;
                    end
                end
                ACT_SYNCALL:
                begin
                    cnt = 0;
                    for (int i = 0; i < N; i++)
                        if (valid[i] && dirty[i])
                        begin
                            if (key_fsid[i] != 0) dirty[i] = 0;
                            cnt++;
                        end
                    r.synced_count = 9'(cnt);
                end
                default: ;
            endcase
            pending.push_back(r);
        endfunction

        // compare a result word with the oldest prediction
        function void check_result(word_t got);
            word_t w;
            if (pending.size() == 0)
            begin
                $error("result word with nothing expected");
                fails++;
                return;
            end
            w = pending.pop_front();
            if (got.status !== w.status)
            begin $error("status exp %0d got %0d", w.status, got.status); fails++; end
            if (got.slot !== w.slot)
            begin $error("slot exp %0d got %0d", w.slot, got.slot); fails++; end
            if (got.hit !== w.hit)
            begin $error("hit exp %0d got %0d", w.hit, got.hit); fails++; end
            if (got.evict_writeback !== w.evict_writeback)
            begin
                $error("evict_writeback exp %0d got %0d", w.evict_writeback,
                       got.evict_writeback);
                fails++;
            end
            if (got.new_inode !== w.new_inode)
            begin $error("new_inode exp %0d got %0d", w.new_inode, got.new_inode); fails++; end
            if (got.was_dirty !== w.was_dirty)
            begin $error("was_dirty exp %0d got %0d", w.was_dirty, got.was_dirty); fails++; end
            if (got.synced_count !== w.synced_count)
            begin
                $error("synced_count exp %0d got %0d", w.synced_count, got.synced_count);
                fails++;
            end
        endfunction
    endclass

    logic        clk = 0;
    logic        rst_n = 0;
    logic        start = 0;
    logic        busy;
    logic [2:0]  action = '0;
    logic [15:0] fs_id = '0;
    logic [31:0] inode_number = '0;
    logic [7:0]  entry_index = '0;
    logic        done;
    logic [1:0]  status;
    logic [7:0]  slot;
    logic        hit;
    logic        evict_writeback;
    logic [31:0] new_inode;
    logic        was_dirty;
    logic [8:0]  synced_count;

    cache_scoreboard board = new();
    longint cycles = 0;

    refcounted_lru_entry_cache u_dut (.*);

    always #5 clk = ~clk;

    // sample result words and keep the watchdog
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (rst_n && done)
            board.check_result({status, slot, hit, evict_writeback, new_inode,
                                was_dirty, synced_count});
        if (cycles > LIMIT)
        begin
            $display("Test completed with failures");
            $finish;
        end
    end

    // issue one command word and wait until it is taken
    task automatic send_word(logic [2:0] a, logic [15:0] f, logic [31:0] n, logic [7:0] x);
        @(negedge clk);
        start <= 1; action <= a; fs_id <= f; inode_number <= n; entry_index <= x;
        forever
        begin
            @(posedge clk);
            if (!busy) break;
        end
        board.note_command(a, f, n, x);
        @(negedge clk);
        start <= 0;
    endtask

    task automatic drain();
        while (board.pending.size() != 0) @(posedge clk);
    endtask

    // mostly well-formed traffic on a few keys, with noise on the fields
    task automatic random_word();
        logic [2:0] a;
        logic [15:0] f;
        logic [31:0] n;
        logic [7:0] x;
        int p;
        p = $urandom_range(0, 99);
        if (p < 35) a = ACT_GET;
        else if (p < 60) a = ACT_PUT;
        else if (p < 68) a = ACT_CREATE;
        else if (p < 76) a = ACT_DESTROY;
        else if (p < 84) a = ACT_DIRTY;
        else if (p < 93) a = ACT_SYNC;
        else if (p < 97) a = ACT_SYNCALL;
        else a = 3'd7;
        f = ($urandom_range(0, 19) == 0) ? 16'($urandom) : 16'($urandom_range(0, 3));
        n = ($urandom_range(0, 9) == 0) ? $urandom : 32'($urandom_range(0, 40));
        x = ($urandom_range(0, 3) == 0) ? 8'($urandom) : 8'($urandom_range(0, 40));
        send_word(a, f, n, x);
    endtask

    initial
    begin
        int burst;
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n <= 1;

        // directed: each action and the edge cases
        send_word(ACT_GET, 16'd0, 32'd5, 8'd0);
        send_word(ACT_GET, 16'hFFFF, 32'hFFFF_FFFF, 8'd0);
        send_word(ACT_GET, 16'hFFFF, 32'hFFFF_FFFF, 8'd0);
        send_word(ACT_CREATE, 16'd0, 32'd0, 8'd0);
        send_word(ACT_SYNC, 16'd1, 32'd0, 8'd2);
        send_word(ACT_SYNCALL, 16'd1, 32'd0, 8'd0);
        send_word(ACT_CREATE, 16'd7, 32'd0, 8'd0);
        send_word(ACT_DIRTY, 16'd0, 32'd0, 8'd0);
        send_word(ACT_SYNC, 16'd0, 32'd0, 8'd0);
        send_word(ACT_SYNC, 16'd0, 32'd0, 8'd0);
        send_word(ACT_PUT, 16'd0, 32'd0, 8'd0);
        send_word(ACT_PUT, 16'd0, 32'd0, 8'd0);
        send_word(ACT_PUT, 16'd0, 32'd0, 8'd0);
        send_word(ACT_DESTROY, 16'd0, 32'd0, 8'd1);
        send_word(ACT_DESTROY, 16'd0, 32'd0, 8'd255);
        send_word(ACT_DIRTY, 16'd0, 32'd0, 8'd255);
        send_word(ACT_SYNC, 16'd0, 32'd0, 8'd255);
        send_word(3'd7, 16'hFFFF, 32'hFFFF_FFFF, 8'hFF);
        send_word(ACT_GET, 16'd1, 32'd0, 8'd0);
        send_word(ACT_GET, 16'd1, 32'd0, 8'd0);

        // fill the whole table with references, then hit cache full
        for (int i = 0; i < N; i++) send_word(ACT_CREATE, 16'd3, 32'd0, 8'd0);
        send_word(ACT_CREATE, 16'd3, 32'd0, 8'd0);
        send_word(ACT_GET, 16'd9, 32'd9, 8'd0);
        send_word(ACT_SYNCALL, 16'd0, 32'd0, 8'd0);
        // release everything so later traffic has room
        for (int i = 0; i < N; i++) send_word(ACT_PUT, 16'd0, 32'd0, 8'(i));

        // pause until everything has come back
        drain();

        // random traffic in bursts with gaps
        for (int k = 0; k < 170; )
        begin
            burst = $urandom_range(1, 20);
            for (int b = 0; b < burst; b++)
            begin
                random_word();
                k++;
            end
            if ($urandom_range(0, 1)) repeat ($urandom_range(1, 12)) @(posedge clk);
        end

        drain();
        repeat (N + 20) @(posedge clk);
        if (board.fails == 0 && board.pending.size() == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end
endmodule

// ===== refcounted_lru_entry_cache.f =====
design/rlc_pkg.sv
design/refcounted_lru_entry_cache.sv
test/refcounted_lru_entry_cache_test.sv
